/* rtl/core/ffve_pkg.sv */
// Package: shared types, codes and constants of the form field value extractor.
`default_nettype none
package ffve_pkg;

  localparam int unsigned MaxKeyLenDefault = 8;
  localparam int unsigned CfgAddrWidth     = 5;
  localparam int unsigned CfgDataWidth     = 64;

  localparam logic [7:0] CharEq  = 8'h3D;
  localparam logic [7:0] CharAmp = 8'h26;
  localparam logic [7:0] CharNul = 8'h00;

  typedef enum logic [1:0] {
    REG_KEY_BYTES  = 2'd0,
    REG_KEY_LENGTH = 2'd1,
    REG_SPLIT_MODE = 2'd2,
    REG_NONE       = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SCAN  = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic        split_mode;
  } cfg_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] value_char;
    logic       done_res;
    logic       found;
  } res_t;

endpackage
`default_nettype wire

/* rtl/core/ffve_cfg.sv */
// Configuration register file behind the APB-style port.
`default_nettype none
module ffve_cfg
  import ffve_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CfgAddrWidth-1:0] paddr,
  input  wire logic [CfgDataWidth-1:0] pwdata,
  output logic      [CfgDataWidth-1:0] prdata,
  output cfg_t                         cfg_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e idx;
  logic     wr_en;

  assign idx   = cfg_idx_e'(paddr[4:3]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_KEY_BYTES:  cfg_d.key_bytes  = pwdata;
        REG_KEY_LENGTH: cfg_d.key_length = pwdata[3:0];
        REG_SPLIT_MODE: cfg_d.split_mode = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_BYTES:  prdata = cfg_q.key_bytes;
      REG_KEY_LENGTH: prdata = {60'd0, cfg_q.key_length};
      REG_SPLIT_MODE: prdata = {63'd0, cfg_q.split_mode};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* rtl/core/ffve_scan.sv */
// Token scanner: per-string state and the one-byte step that forms a result.
`default_nettype none
module ffve_scan
  import ffve_pkg::*;
#(
  parameter int unsigned MAX_KEY_LEN = MaxKeyLenDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] char_i,
  input  wire logic       eos_i,
  input  wire cfg_t       cfg_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  localparam int unsigned TcWidth = $clog2(MAX_KEY_LEN + 2);
  localparam logic [TcWidth-1:0] TcSat = TcWidth'(MAX_KEY_LEN + 1);
  localparam logic [3:0] KlenMax = 4'(MAX_KEY_LEN);

  phase_e             phase_q, phase_d;
  logic [TcWidth-1:0] tc_q, tc_d;
  logic               pe_q, pe_d;
  logic               vs_q, vs_d;

  logic [3:0] klen;
  logic [3:0] tc4;
  logic [7:0] kc;
  logic       is_sep;
  logic       emit;

  assign klen   = (cfg_i.key_length > KlenMax) ? KlenMax : cfg_i.key_length;
  assign tc4    = 4'(tc_q);
  assign is_sep = (char_i == CharEq) || (char_i == CharAmp);

  always_comb begin
    kc = '0;
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      if (tc_q == TcWidth'(i)) kc = cfg_i.key_bytes[8*i +: 8];
    end
  end

  always_comb begin
    phase_d = phase_q;
    tc_d    = tc_q;
    pe_d    = pe_q;
    vs_d    = vs_q;
    emit    = 1'b0;
    case (phase_q)
      PH_SCAN: begin
        if (char_i == CharNul) begin
          phase_d = PH_SKIP;
        end else if (is_sep) begin
          if (!(cfg_i.split_mode && (tc_q == '0))) begin
            if (pe_q && (tc4 == klen)) begin
              phase_d = PH_VALUE;
              vs_d    = 1'b0;
            end
            tc_d = '0;
            pe_d = 1'b1;
          end
        end else begin
          if (tc4 < klen) begin
            if (kc != char_i) pe_d = 1'b0;
          end else begin
            pe_d = 1'b0;
          end
          if (tc_q < TcSat) tc_d = tc_q + 1'b1;
        end
      end
      PH_VALUE: begin
        if (char_i == CharNul) begin
          phase_d = PH_SKIP;
        end else if (char_i == CharAmp) begin
          if (!cfg_i.split_mode) begin
            vs_d    = 1'b1;
            phase_d = PH_SKIP;
          end else if (vs_q) begin
            phase_d = PH_SKIP;
          end
        end else begin
          vs_d = 1'b1;
          emit = 1'b1;
        end
      end
      PH_SKIP: ;
      default: phase_d = PH_SCAN;
    endcase

    res_valid_o      = step_i && (emit || eos_i);
    res_o.byte_valid = emit;
    res_o.value_char = emit ? char_i : 8'd0;
    res_o.done_res   = eos_i;
    res_o.found      = eos_i && vs_d;

    if (eos_i) begin
      phase_d = PH_SCAN;
      tc_d    = '0;
      pe_d    = 1'b1;
      vs_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SCAN;
      tc_q    <= '0;
      pe_q    <= 1'b1;
      vs_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tc_q    <= tc_d;
      pe_q    <= pe_d;
      vs_q    <= vs_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ffve_outbuf.sv */
// Output register with a skid stage between the scanner and the result channel.
`default_nettype none
module ffve_outbuf
  import ffve_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  wire res_t res_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_o
);

  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;
  logic take;

  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) out_q <= skid_q;
    end else if (res_valid_i) begin
      if (!out_v_q || take) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid holds an item while output is empty");
  a_stalled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> out_v_q) else $error("stalled item dropped");
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.found) |-> out_q.done_res) else $error("found without done");
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.byte_valid || out_q.done_res)) else $error("empty item");

endmodule
`default_nettype wire

/* rtl/core/form_field_value_extractor_top.sv */
// Top level of the form field value extractor.
// Takes one byte of a form-encoded string per cycle while not stalled and streams out the
// value of the first token equal to the configured key, then reports found or not found on
// the string's last byte. The scanner state is updated in a single step, and one result per
// cycle, while out_stall_i is low, leaves through an output register backed by a one-entry
// skid stage, so input stalls only while both are full. Registers sit at byte addresses 0
// (key_bytes), 8 (key_length) and 16 (split_mode); write them only while the block is idle.
`default_nettype none
module form_field_value_extractor_top
  import ffve_pkg::*;
#(
  parameter int unsigned MAX_KEY_LEN = MaxKeyLenDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CfgAddrWidth-1:0] paddr,
  input  wire logic [CfgDataWidth-1:0] pwdata,
  output logic      [CfgDataWidth-1:0] prdata,
  output logic                         pready,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [7:0]              char_in_i,
  input  wire logic                    end_of_string_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         byte_valid_o,
  output logic      [7:0]              value_char_o,
  output logic                         done_res_o,
  output logic                         found_o
);

  cfg_t cfg;
  res_t res, out_res;
  logic res_valid;
  logic full;
  logic step;

  assign pready     = 1'b1;
  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  ffve_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  ffve_scan #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_i      (char_in_i),
    .eos_i       (end_of_string_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ffve_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign byte_valid_o = out_res.byte_valid;
  assign value_char_o = out_res.value_char;
  assign done_res_o   = out_res.done_res;
  assign found_o      = out_res.found;

endmodule
`default_nettype wire

/* test/form_field_value_extractor_top_tb.sv */
// Testbench: drives form strings into the form field value extractor and checks every result.
`timescale 1ns / 100ps
module form_field_value_extractor_top_tb;
  import ffve_pkg::*;

  localparam int unsigned MAX_KEY_LEN = MaxKeyLenDefault;
  localparam int unsigned ROUNDS      = 12;
  localparam int unsigned ROUND_BYTES = 80;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } form_byte_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    psel            = 1'b0;
  logic                    penable         = 1'b0;
  logic                    pwrite          = 1'b0;
  logic [CfgAddrWidth-1:0] paddr           = '0;
  logic [CfgDataWidth-1:0] pwdata          = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              char_in_i       = '0;
  logic                    end_of_string_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic                    byte_valid_o;
  logic [7:0]              value_char_o;
  logic                    done_res_o;
  logic                    found_o;

  form_byte_t  form_bytes_q[$];
  res_t        value_res_q[$];
  form_byte_t  next_byte;
  res_t        seen_res;
  res_t        due_res;
  int unsigned queued_cnt     = 0;
  int unsigned err_cnt        = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_done     = 0;
  int unsigned hold_left      = 0;

  cfg_t        cur_cfg     = '0;
  phase_e      scan_phase  = PH_SCAN;
  int unsigned tok_len     = 0;
  logic        tok_match   = 1'b1;
  logic        val_seen    = 1'b0;

  form_field_value_extractor_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_valid_o   (byte_valid_o),
    .value_char_o   (value_char_o),
    .done_res_o     (done_res_o),
    .found_o        (found_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int unsigned key_len_eff();
    return (cur_cfg.key_length > MAX_KEY_LEN) ? MAX_KEY_LEN : int'(cur_cfg.key_length);
  endfunction

  function automatic void track_form_byte(logic [7:0] c, logic eos);
    int unsigned klen;
    logic        emit;
    res_t        r;
    klen = key_len_eff();
    emit = 1'b0;
    case (scan_phase)
      PH_SCAN: begin
        if (c == CharNul) begin
          scan_phase = PH_SKIP;
        end else if (c == CharEq || c == CharAmp) begin
          if (!(cur_cfg.split_mode && tok_len == 0)) begin
            if (tok_match && tok_len == klen) begin
              scan_phase = PH_VALUE;
              val_seen   = 1'b0;
            end
            tok_len   = 0;
            tok_match = 1'b1;
          end
        end else begin
          if (tok_len < klen) begin
            if (cur_cfg.key_bytes[8*tok_len +: 8] != c) tok_match = 1'b0;
          end else begin
            tok_match = 1'b0;
          end
          if (tok_len < MAX_KEY_LEN + 1) tok_len++;
        end
      end
      PH_VALUE: begin
        if (c == CharNul) begin
          scan_phase = PH_SKIP;
        end else if (c == CharAmp) begin
          if (!cur_cfg.split_mode) begin
            val_seen   = 1'b1;
            scan_phase = PH_SKIP;
          end else if (val_seen) begin
            scan_phase = PH_SKIP;
          end
        end else begin
          val_seen = 1'b1;
          emit     = 1'b1;
        end
      end
      default: ;
    endcase
    if (emit || eos) begin
      r.byte_valid = emit;
      r.value_char = emit ? c : 8'h00;
      r.done_res   = eos;
      r.found      = eos && val_seen;
      value_res_q.push_back(r);
    end
    if (eos) begin
      scan_phase = PH_SCAN;
      tok_len    = 0;
      tok_match  = 1'b1;
      val_seen   = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_valid_i) track_form_byte(char_in_i, end_of_string_i);
      if (form_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = form_bytes_q.pop_front();
        in_valid_i      <= 1'b1;
        char_in_i       <= next_byte.ch;
        end_of_string_i <= next_byte.eos;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done  = holds_done + 1;
      hold_left   = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_res.byte_valid = byte_valid_o;
      seen_res.value_char = value_char_o;
      seen_res.done_res   = done_res_o;
      seen_res.found      = found_o;
      if (value_res_q.size() == 0) begin
        note_error($sformatf("%0t: unexpected result bv=%0b ch=%02h done=%0b found=%0b",
                             $realtime, byte_valid_o, value_char_o, done_res_o, found_o));
      end else begin
        due_res = value_res_q.pop_front();
        if (seen_res.byte_valid !== due_res.byte_valid ||
            seen_res.value_char !== due_res.value_char ||
            seen_res.done_res !== due_res.done_res || seen_res.found !== due_res.found) begin
          note_error($sformatf(
              "%0t: mismatch exp bv=%0b ch=%02h done=%0b found=%0b got bv=%0b ch=%02h done=%0b found=%0b",
              $realtime, due_res.byte_valid, due_res.value_char, due_res.done_res,
              due_res.found, seen_res.byte_valid, seen_res.value_char, seen_res.done_res,
              seen_res.found));
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrWidth'(int'(idx) * 8);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KEY_BYTES:  cur_cfg.key_bytes  = val;
      REG_KEY_LENGTH: cur_cfg.key_length = val[3:0];
      REG_SPLIT_MODE: cur_cfg.split_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic set_key(logic [63:0] kb, logic [3:0] kl, logic sm);
    write_reg(REG_KEY_BYTES, kb);
    write_reg(REG_KEY_LENGTH, 64'(kl));
    write_reg(REG_SPLIT_MODE, 64'(sm));
  endtask

  task automatic wait_drained();
    while (form_bytes_q.size() != 0 || in_valid_i || value_res_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (10) @(posedge clk_i);
  endtask

  task automatic push_byte(logic [7:0] c, logic eos);
    form_byte_t b;
    b.ch  = c;
    b.eos = eos;
    form_bytes_q.push_back(b);
    queued_cnt++;
  endtask

  task automatic push_text(string s, logic ends);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], ends && i == s.len() - 1);
  endtask

  function automatic logic [7:0] key_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 8'(8'h61 + $urandom_range(2));
    if (r < 95) return 8'($urandom_range(1, 255));
    case ($urandom_range(2))
      0: return CharEq;
      1: return CharAmp;
      default: return CharNul;
    endcase
  endfunction

  function automatic logic [7:0] filler_char();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return 8'(8'h61 + $urandom_range(2));
    if (r < 8) return 8'h78;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic queue_form();
    logic [7:0]  text[$];
    int unsigned klen;
    int unsigned ntok;
    int unsigned pick;
    klen = key_len_eff();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
    end else begin
      ntok = $urandom_range(1, 5);
      for (int t = 0; t < ntok; t++) begin
        pick = $urandom_range(5);
        if (pick <= 1) begin
          for (int i = 0; i < klen; i++) text.push_back(cur_cfg.key_bytes[8*i +: 8]);
        end else if (pick == 2) begin
          if (klen > 0 && $urandom_range(1)) begin
            for (int i = 0; i < klen - 1; i++) text.push_back(cur_cfg.key_bytes[8*i +: 8]);
          end else begin
            for (int i = 0; i < klen; i++) text.push_back(cur_cfg.key_bytes[8*i +: 8]);
            text.push_back(filler_char());
          end
        end else if (pick == 3) begin
          repeat ($urandom_range(3)) text.push_back(filler_char());
        end else if (pick == 5) begin
          repeat ($urandom_range(1, 4))
            text.push_back(($urandom_range(3) == 0) ? CharEq : filler_char());
        end
        if (t + 1 < ntok || $urandom_range(1)) begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4: text.push_back(CharEq);
            5, 6, 7:       text.push_back(CharAmp);
            8: begin
              text.push_back(CharAmp);
              text.push_back(CharAmp);
            end
            default: begin
              text.push_back(CharEq);
              text.push_back(CharAmp);
              text.push_back(CharAmp);
            end
          endcase
        end
      end
      if ($urandom_range(7) == 0) text.insert($urandom_range(text.size()), CharNul);
      if (text.size() == 0) text.push_back(filler_char());
    end
    for (int i = 0; i < text.size(); i++) push_byte(text[i], i == text.size() - 1);
  endtask

  initial begin
    logic [63:0] kb;
    logic [3:0]  kl;
    logic        sm;
    int unsigned target;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // key "ab", single separators
    set_key(64'h6261, 4'd2, 1'b0);
    push_text("ab=c=d", 1'b1);
    push_text("ab&y", 1'b1);
    push_text("ab", 1'b1);
    push_text("ab=", 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(CharNul, 1'b0);
    push_byte(8'h62, 1'b1);
    wait_idle();
    write_reg(REG_SPLIT_MODE, 64'd1);
    push_text("&ab=&v", 1'b1);
    push_text("ab=&", 1'b1);

    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      wait_idle();
      for (int i = 0; i < 8; i++) kb[8*i +: 8] = key_char();
      kl = 4'($urandom_range(1, 8));
      sm = 1'($urandom_range(1));
      case (rnd)
        0: begin
          kb = '1;
          kl = 4'd8;
          sm = 1'b0;
        end
        1: begin
          kl = 4'd0;
          sm = 1'b0;
        end
        2: begin
          kl = 4'd15;
          sm = 1'b1;
        end
        3: begin
          kb = '0;
          kl = 4'd4;
        end
        4: kl = 4'd0;
        7: kl = 4'($urandom_range(9, 15));
        default: ;
      endcase
      set_key(kb, kl, sm);
      case (rnd % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      target = queued_cnt + ROUND_BYTES;
      if (rnd == 6) holds_asked++;
      if (rnd == 5) begin
        while (queued_cnt < target - ROUND_BYTES / 2) queue_form();
        wait_drained();
      end
      while (queued_cnt < target) queue_form();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && value_res_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
